// File: src/ptsb_pkg.sv
// Shared types and constants for the periodic timer slot bank.
package ptsb_pkg;

	// Bank size and derived widths
	localparam int SLOTS = 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W  = 4;

	// Command kinds
	localparam logic [1:0] KIND_REG   = 2'd0;
	localparam logic [1:0] KIND_UNREG = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;

	// Command transfer payload
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] delay_ms;
		logic [3:0]  slot_number;
		logic [31:0] now_ms;
	} timer_in_t;

	// Result transfer payload
	typedef struct packed {
		logic [ID_W-1:0] slot_id;
		logic            fired;
		logic            last;
	} timer_out_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_REG   = 4'b0010,
		ST_CHK   = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

endpackage

// File: src/periodic_timer_slot_bank.sv
// Top level of the periodic timer slot bank: slot store, sequencer and result register.
//
//   channel   direction  handshake                 payload
//   command   in         start & !busy             cmd (timer_in_t)
//   result    out        rsp_valid, one cycle      rsp (timer_out_t)
//
// A register item scans slots one per cycle through the slot store, up to the first free slot.
// A check item runs every slot once through the single expiry unit, then a flush state.
// Unregister and unknown kinds are handled in the idle state with busy low.
// Register, unregister and unknown results appear the cycle after they are decided; a check
// holds each firing back until the next hit or the flush cycle releases it.
// Reset clears all slots to free. The receiver cannot stall, so results never wait.
module periodic_timer_slot_bank
	import ptsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  timer_in_t  cmd,
	output logic       rsp_valid,
	output timer_out_t rsp
);

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SLOTS-1:0]   active_q;
	logic [31:0]        start_q [SLOTS];
	logic [15:0]        period_q [SLOTS];
	logic [31:0]        now_q;
	logic [15:0]        delay_q;
	logic               pend_q;
	logic [ID_W-1:0]    pend_id_q;
	logic               rsp_valid_q;
	timer_out_t         rsp_q;

	logic               accept;
	logic               expired;
	logic               idx_end;
	logic [ID_W-1:0]    idx_id;
	logic               unreg_ok;
	logic [IDX_W-1:0]   unreg_idx;
	logic [ID_W-1:0]    num_m1;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign idx_end   = (idx_q == IDX_W'(SLOTS - 1));
	assign idx_id    = ID_W'(idx_q) + ID_W'(1);
	assign num_m1    = cmd.slot_number - ID_W'(1);
	assign unreg_idx = num_m1[IDX_W-1:0];
	assign unreg_ok  = (cmd.slot_number >= ID_W'(1)) && (cmd.slot_number <= ID_W'(SLOTS))
		&& active_q[unreg_idx];

	// Shared expiry unit, fed by the scan index
	ptsb_expiry_cmp u_cmp (
		.now_ms    (now_q),
		.start_ms  (start_q[idx_q]),
		.period_ms (period_q[idx_q]),
		.expired   (expired)
	);

	// Sequencer, slot activity and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			active_q    <= '0;
			pend_q      <= 1'b0;
			pend_id_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						case (cmd.kind)
							KIND_REG:   state_q <= ST_REG;
							KIND_CHECK: state_q <= ST_CHK;
							KIND_UNREG: begin
								// Free the named slot at once
								if (unreg_ok) begin
									active_q[unreg_idx] <= 1'b0;
								end
								rsp_valid_q   <= 1'b1;
								rsp_q.slot_id <= unreg_ok ? cmd.slot_number : '0;
								rsp_q.fired   <= 1'b0;
								rsp_q.last    <= 1'b1;
							end
							default: begin
								// Drop unknown kinds with an empty result
								rsp_valid_q <= 1'b1;
								rsp_q       <= '{slot_id: '0, fired: 1'b0, last: 1'b1};
							end
						endcase
					end
				end
				ST_REG: begin
					// Claim the first free slot, or report a full bank
					if (!active_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
						rsp_valid_q     <= 1'b1;
						rsp_q           <= '{slot_id: idx_id, fired: 1'b0, last: 1'b1};
						state_q         <= ST_IDLE;
					end else if (idx_end) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{slot_id: '0, fired: 1'b0, last: 1'b1};
						state_q     <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_CHK: begin
					// Hold each firing back one hit so the final one can carry last
					if (active_q[idx_q] && expired) begin
						if (pend_q) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{slot_id: pend_id_q, fired: 1'b1, last: 1'b0};
						end
						pend_q    <= 1'b1;
						pend_id_q <= idx_id;
					end
					if (idx_end) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					// Release the held firing, or an empty result if nothing fired
					rsp_valid_q <= 1'b1;
					if (pend_q) begin
						rsp_q <= '{slot_id: pend_id_q, fired: 1'b1, last: 1'b1};
					end else begin
						rsp_q <= '{slot_id: '0, fired: 1'b0, last: 1'b1};
					end
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the command time and period
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= cmd.now_ms;
			delay_q <= cmd.delay_ms;
		end
	end

	// Slot store: write start and period on claim, restart on expiry
	always_ff @(posedge clk) begin
		if (state_q == ST_REG && !active_q[idx_q]) begin
			start_q[idx_q]  <= now_q;
			period_q[idx_q] <= delay_q;
		end else if (state_q == ST_CHK && active_q[idx_q] && expired) begin
			start_q[idx_q] <= now_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/ptsb_expiry_cmp.sv
// Shared expiry unit: wrapped elapsed time compared against a slot period.
module ptsb_expiry_cmp
	import ptsb_pkg::*;
(
	input  logic [31:0] now_ms,
	input  logic [31:0] start_ms,
	input  logic [15:0] period_ms,
	output logic        expired
);

	logic [31:0] elapsed;

	// Take elapsed time modulo 2^32, then compare with the zero-extended period
	always_comb begin
		elapsed = now_ms - start_ms;
		expired = elapsed > {16'd0, period_ms};
	end

endmodule
